// ----- rtl/tsbm_pkg.sv -----
// Package for the two-wire sensor bus master: item and configuration types,
// command codes, register indexes, reset values and protocol constants.
// No dependencies.
`default_nettype none

package tsbm_pkg;

    // command codes on the op field
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_TEMP      = 3'd1;
    localparam logic [2:0] OP_HUMID     = 3'd2;
    localparam logic [2:0] OP_SOFT_RST  = 3'd3;
    localparam logic [2:0] OP_CONN_RST  = 3'd4;

    // command bytes sent on the wire
    localparam logic [7:0] CMD_BYTE_TEMP     = 8'h03;
    localparam logic [7:0] CMD_BYTE_HUMID    = 8'h05;
    localparam logic [7:0] CMD_BYTE_SOFT_RST = 8'h1e;
    localparam logic [7:0] CMD_BYTE_NONE     = 8'h00;

    // clocks with data high in a connection reset (9 to 16)
    localparam logic [4:0] RESET_CLOCKS = 5'd9;

    // status codes on done
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PHASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PHASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT    = 3'd3;

    localparam logic [7:0]  LONG_PHASE_RST    = 8'd3;
    localparam logic [7:0]  SHORT_PHASE_RST   = 8'd1;
    localparam logic [15:0] POLL_INTERVAL_RST = 16'd3000;
    localparam logic [7:0]  POLL_LIMIT_RST    = 8'd240;

    typedef struct packed {
        logic [2:0] op;
        logic       data_line;
    } t_in_item;

    typedef struct packed {
        logic        clock_line;
        logic        data_drive;
        logic        data_level;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] measurement;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  long_phase_ticks;
        logic [7:0]  short_phase_ticks;
        logic [15:0] poll_interval_ticks;
        logic [7:0]  poll_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/tsbm_cfg.sv -----
// Configuration register file of the two-wire sensor bus master.
// Depends on tsbm_pkg.
`default_nettype none

module tsbm_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tsbm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tsbm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output tsbm_pkg::t_cfg                          o_cfg
);

    tsbm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_phase_ticks    <= tsbm_pkg::LONG_PHASE_RST;
            r_cfg.short_phase_ticks   <= tsbm_pkg::SHORT_PHASE_RST;
            r_cfg.poll_interval_ticks <= tsbm_pkg::POLL_INTERVAL_RST;
            r_cfg.poll_limit          <= tsbm_pkg::POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsbm_pkg::REG_LONG_PHASE:    r_cfg.long_phase_ticks    <= i_cfg_wdata[7:0];
                tsbm_pkg::REG_SHORT_PHASE:   r_cfg.short_phase_ticks   <= i_cfg_wdata[7:0];
                tsbm_pkg::REG_POLL_INTERVAL: r_cfg.poll_interval_ticks <= i_cfg_wdata;
                tsbm_pkg::REG_POLL_LIMIT:    r_cfg.poll_limit          <= i_cfg_wdata[7:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/tsbm_seq.sv -----
// Bus sequencer of the two-wire sensor bus master: phase state machine,
// counters and the registered per-tick result. Depends on tsbm_pkg.
`default_nettype none

module tsbm_seq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire tsbm_pkg::t_in_item    i_item,
    input  wire tsbm_pkg::t_cfg        i_cfg,
    output tsbm_pkg::t_out_item        o_item
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_RST_HI, PH_RST_LO,
        PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5, PH_S6,
        PH_W_HI, PH_W_LO, PH_ACK_HI, PH_ACK_OK, PH_ACK_BAD, PH_POLL,
        PH_R_HI, PH_R_LO, PH_RA_HI, PH_RA_LO,
        PH_FIN_OK, PH_FIN_NACK, PH_FIN_TOUT
    } t_phase;

    t_phase              r_phase, n_phase, cur_phase;
    logic [3:0]          r_bc, n_bc;
    logic [15:0]         r_timer, n_timer, timer_dec;
    logic [7:0]          r_poll, n_poll;
    logic [15:0]         r_word, n_word;
    logic [7:0]          r_cmd, n_cmd;
    logic [2:0]          r_act, n_act;
    tsbm_pkg::t_out_item r_out, n_out;
    logic                start;
    logic                lvl;
    logic [4:0]          bc_inc;

    function automatic logic [15:0] nz16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // phase length in ticks on entry; zero registers act as one
    function automatic logic [15:0] phase_ticks(input t_phase ph, input tsbm_pkg::t_cfg c);
        logic [15:0] d;
        unique case (ph)
            PH_RST_HI, PH_RST_LO, PH_S3, PH_W_HI, PH_ACK_HI, PH_RA_HI:
                d = {8'd0, c.long_phase_ticks};
            PH_POLL:
                d = c.poll_interval_ticks;
            default:
                d = {8'd0, c.short_phase_ticks};
        endcase
        return nz16(d);
    endfunction

    assign start = (r_phase == PH_IDLE) &&
                   (i_item.op == tsbm_pkg::OP_TEMP || i_item.op == tsbm_pkg::OP_HUMID ||
                    i_item.op == tsbm_pkg::OP_SOFT_RST || i_item.op == tsbm_pkg::OP_CONN_RST);
    assign bc_inc = {1'b0, r_bc} + 5'd1;

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_timer = r_timer;
        n_poll  = r_poll;
        n_word  = r_word;
        n_cmd   = r_cmd;
        n_act   = r_act;
        n_out   = '0;
        lvl     = 1'b0;

        if (start) begin
            n_act  = i_item.op;
            unique case (i_item.op)
                tsbm_pkg::OP_TEMP:     n_cmd = tsbm_pkg::CMD_BYTE_TEMP;
                tsbm_pkg::OP_HUMID:    n_cmd = tsbm_pkg::CMD_BYTE_HUMID;
                tsbm_pkg::OP_SOFT_RST: n_cmd = tsbm_pkg::CMD_BYTE_SOFT_RST;
                default:               n_cmd = tsbm_pkg::CMD_BYTE_NONE;
            endcase
            n_word  = '0;
            n_bc    = '0;
            n_poll  = '0;
            n_phase = (i_item.op == tsbm_pkg::OP_SOFT_RST || i_item.op == tsbm_pkg::OP_CONN_RST)
                      ? PH_RST_HI : PH_S0;
            n_timer = phase_ticks(n_phase, i_cfg);
        end

        cur_phase = n_phase;
        timer_dec = (n_timer == 16'd0) ? 16'd0 : n_timer - 16'd1;

        if (cur_phase == PH_FIN_OK || cur_phase == PH_FIN_NACK ||
            cur_phase == PH_FIN_TOUT) begin
            n_out.done_res    = 1'b1;
            n_out.status      = (cur_phase == PH_FIN_NACK) ? tsbm_pkg::ST_NACK :
                                (cur_phase == PH_FIN_TOUT) ? tsbm_pkg::ST_TIMEOUT :
                                                             tsbm_pkg::ST_OK;
            n_out.measurement = n_word;
            n_phase           = PH_IDLE;
            n_timer           = '0;
        end else if (cur_phase != PH_IDLE) begin
            // pin levels of the current phase
            unique case (cur_phase)
                PH_RST_HI, PH_S1, PH_S5: begin
                    n_out.clock_line = 1'b1; n_out.data_drive = 1'b1; lvl = 1'b1;
                end
                PH_RST_LO, PH_S0, PH_S6: begin
                    n_out.data_drive = 1'b1; lvl = 1'b1;
                end
                PH_S2, PH_S4: begin
                    n_out.clock_line = 1'b1; n_out.data_drive = 1'b1;
                end
                PH_S3: n_out.data_drive = 1'b1;
                PH_W_HI: begin
                    n_out.clock_line = 1'b1; n_out.data_drive = 1'b1;
                    lvl = n_cmd[3'd7 - n_bc[2:0]];
                end
                PH_W_LO: begin
                    n_out.data_drive = 1'b1;
                    lvl = n_cmd[3'd7 - n_bc[2:0]];
                end
                PH_ACK_HI, PH_ACK_OK, PH_ACK_BAD, PH_R_HI: n_out.clock_line = 1'b1;
                PH_RA_HI: begin
                    n_out.clock_line = 1'b1; n_out.data_drive = 1'b1; lvl = n_bc[3];
                end
                PH_RA_LO: begin
                    n_out.data_drive = 1'b1; lvl = n_bc[3];
                end
                default: ;
            endcase
            n_out.data_level = n_out.data_drive & lvl;
            n_out.busy_res   = 1'b1;
            n_timer          = timer_dec;

            if (timer_dec == 16'd0) begin
                unique case (cur_phase)
                    PH_RST_HI: n_phase = PH_RST_LO;
                    PH_RST_LO: begin
                        if (bc_inc >= tsbm_pkg::RESET_CLOCKS) begin
                            n_bc = '0; n_phase = PH_S0;
                        end else begin
                            n_bc = bc_inc[3:0]; n_phase = PH_RST_HI;
                        end
                    end
                    PH_S0: n_phase = PH_S1;
                    PH_S1: n_phase = PH_S2;
                    PH_S2: n_phase = PH_S3;
                    PH_S3: n_phase = PH_S4;
                    PH_S4: n_phase = PH_S5;
                    PH_S5: n_phase = PH_S6;
                    PH_S6: begin
                        if (n_act == tsbm_pkg::OP_CONN_RST) begin
                            n_phase = PH_FIN_OK;
                        end else begin
                            n_bc = '0; n_phase = PH_W_HI;
                        end
                    end
                    PH_W_HI: n_phase = PH_W_LO;
                    PH_W_LO: begin
                        if (n_bc >= 4'd7) begin
                            n_phase = PH_ACK_HI;
                        end else begin
                            n_bc = n_bc + 4'd1; n_phase = PH_W_HI;
                        end
                    end
                    PH_ACK_HI:  n_phase = i_item.data_line ? PH_ACK_BAD : PH_ACK_OK;
                    PH_ACK_BAD: n_phase = PH_FIN_NACK;
                    PH_ACK_OK: begin
                        if (n_act == tsbm_pkg::OP_SOFT_RST) begin
                            n_phase = PH_FIN_OK;
                        end else begin
                            n_poll = '0; n_phase = PH_POLL;
                        end
                    end
                    PH_POLL: begin
                        if (!i_item.data_line) begin
                            n_bc = '0; n_phase = PH_R_HI;
                        end else begin
                            n_poll = n_poll + 8'd1;
                            n_phase = ({8'd0, n_poll} >= nz16({8'd0, i_cfg.poll_limit}))
                                      ? PH_FIN_TOUT : PH_POLL;
                        end
                    end
                    PH_R_HI: begin
                        n_word  = {n_word[14:0], i_item.data_line};
                        n_phase = PH_R_LO;
                    end
                    PH_R_LO: begin
                        if (n_bc[2:0] == 3'b111) begin
                            n_phase = PH_RA_HI;
                        end else begin
                            n_bc = n_bc + 4'd1; n_phase = PH_R_HI;
                        end
                    end
                    PH_RA_HI: n_phase = PH_RA_LO;
                    PH_RA_LO: begin
                        if (n_bc == 4'd15) begin
                            n_phase = PH_FIN_OK;
                        end else begin
                            n_bc = 4'd8; n_phase = PH_R_HI;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
                n_timer = phase_ticks(n_phase, i_cfg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bc    <= '0;
            r_timer <= '0;
            r_poll  <= '0;
            r_word  <= '0;
            r_cmd   <= '0;
            r_act   <= '0;
            r_out   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_timer <= n_timer;
            r_poll  <= n_poll;
            r_word  <= n_word;
            r_cmd   <= n_cmd;
            r_act   <= n_act;
            r_out   <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

// ----- rtl/two_wire_sensor_bus_master.sv -----
// Top level of the two-wire sensor bus master: handshakes, configuration
// registers and the bus sequencer. Depends on tsbm_pkg, tsbm_cfg, tsbm_seq.
`default_nettype none

// Each input transaction is one timing tick of the sensor bus and yields exactly
// one output transaction with the pin levels and status for that tick. The block
// takes one tick per clock: the whole step of the phase state machine sits
// between the sequencer state and the result register, so a new transaction is
// accepted every cycle and its result shows in the next cycle. The result register
// takes the next tick on the same edge that the waiting result is drained; the
// input side only stalls when a result is pending and the consumer holds off.
// Commands (op 1 to 4) start only from idle; op 0 and op 5 to 7 just advance time.
// Timing registers (long/short phase, poll interval, poll limit) must be written
// by the user via the write port only while no command runs (not enforced); zero
// acts as one. data_line is sampled on the last tick of the acknowledge, poll and
// read-bit phases. The done tick drops busy and carries status and measurement.
module two_wire_sensor_bus_master (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // tick transactions in
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire tsbm_pkg::t_in_item                 i_in,
    // per-tick results out
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output tsbm_pkg::t_out_item                     o_out,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [tsbm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tsbm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    tsbm_pkg::t_cfg cfg;
    logic           step;
    logic           r_out_valid;

    // result register can take a new tick when empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    tsbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tsbm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (i_in),
        .i_cfg   (cfg),
        .o_item  (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/tsbm_checker.sv -----
// Port-level checker for the two-wire sensor bus master, with its bind.
// Depends on tsbm_pkg and the top level's port list.
`default_nettype none

module tsbm_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire tsbm_pkg::t_out_item o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // done tick releases the bus and is not busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |->
            !o_out.busy_res && !o_out.clock_line && !o_out.data_drive)
        else $error("done tick drives the bus");

    // a released data line carries no level
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.data_drive |-> !o_out.data_level)
        else $error("level set while data released");

    // status and measurement only on done
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.done_res |->
            o_out.status == tsbm_pkg::ST_OK && o_out.measurement == 16'd0)
        else $error("status outside done tick");

    // an accepted tick always leaves a result pending
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted tick gave no result");

endmodule

bind two_wire_sensor_bus_master tsbm_checker u_tsbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
